>>> sv/blos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blos_pkg;

    // default map size
    localparam int BLOS_MAP_WIDTH  = 128;
    localparam int BLOS_MAP_HEIGHT = 64;

    // fixed field widths
    localparam int X_W   = 7;
    localparam int Y_W   = 6;
    localparam int ERR_W = 9;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_VIEWER_X = 1'b0;
    localparam logic CFG_VIEWER_Y = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

>>> sv/bresenham_line_of_sight_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake             Payload
// in       input      i_in_valid/o_in_stall  operation, cell_x, cell_y, blocked
// out      output     o_out_valid/i_out_stall visible, was_query
// cfg      input      i_cfg_we              i_cfg_index, i_cfg_data (no read-back)
//
// A query visits the cells on the line one by one, at most the longer delta plus
// one cells, so up to 128 cells on the default map.
// The loop is the single read port of the obstacle RAM: one cell per cycle.
// After reset the RAM is cleared one cell a cycle (all min(MAP_WIDTH,128) x
// min(MAP_HEIGHT,64) cells, 8192 by default); no input is taken meanwhile.
// A new item is taken while a result waits in the output register; an item that
// finishes while that register is still full holds there until it drains.

module bresenham_line_of_sight_unit
    import blos_pkg::*;
#(
    parameter int MAP_WIDTH  = BLOS_MAP_WIDTH,
    parameter int MAP_HEIGHT = BLOS_MAP_HEIGHT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire              i_in_operation,
    input  wire [X_W-1:0]    i_in_cell_x,
    input  wire [Y_W-1:0]    i_in_cell_y,
    input  wire              i_in_blocked,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic             o_out_visible,
    output logic             o_out_was_query,
    input  wire              i_cfg_we,
    input  wire              i_cfg_index,
    input  wire [X_W-1:0]    i_cfg_data
);

    // only cells that the field widths can reach are stored
    localparam int EFF_W = (MAP_WIDTH  < (1 << X_W)) ? MAP_WIDTH  : (1 << X_W);
    localparam int EFF_H = (MAP_HEIGHT < (1 << Y_W)) ? MAP_HEIGHT : (1 << Y_W);
    localparam int DEPTH = EFF_W * EFF_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = 13;

    function automatic logic [AW-1:0] f_addr(input logic [X_W-1:0] x,
                                             input logic [Y_W-1:0] y);
        logic [AW+Y_W-1:0] prod;
        begin
            prod   = (AW+Y_W)'(y) * (AW+Y_W)'(EFF_W);
            f_addr = prod[AW-1:0] + AW'(x);
        end
    endfunction

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr;
    logic [X_W-1:0]          r_vx, r_x, r_tx, n_x;
    logic [Y_W-1:0]          r_vy, r_y, r_ty, n_y;
    logic [X_W-1:0]          r_dx;
    logic [Y_W-1:0]          r_dy;
    logic                    r_sx, r_sy;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic                    r_out_valid, r_visible, r_was_query;
    logic                    r_pend_vis, r_pend_query;

    logic                    in_acc, out_free;
    logic                    tgt_in_map, view_in_map;
    logic                    ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [X_W-1:0]          dx_new;
    logic [Y_W-1:0]          dy_new;
    logic signed [ERR_W-1:0] err_new, dx_s, dy_s;
    logic                    step_x, step_y, at_tgt;
    logic                    fin, fin_vis, fin_query;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_out_visible   = r_visible;
    assign o_out_was_query = r_was_query;

    assign tgt_in_map  = (CMP_W'(i_in_cell_x) < CMP_W'(MAP_WIDTH)) &&
                         (CMP_W'(i_in_cell_y) < CMP_W'(MAP_HEIGHT));
    assign view_in_map = (CMP_W'(r_vx) < CMP_W'(MAP_WIDTH)) &&
                         (CMP_W'(r_vy) < CMP_W'(MAP_HEIGHT));

    assign dx_new  = (i_in_cell_x > r_vx) ? i_in_cell_x - r_vx : r_vx - i_in_cell_x;
    assign dy_new  = (i_in_cell_y > r_vy) ? i_in_cell_y - r_vy : r_vy - i_in_cell_y;
    assign err_new = (ERR_W'(dx_new) > ERR_W'(dy_new))
                   ? $signed(ERR_W'(dx_new[X_W-1:1]))
                   : -$signed(ERR_W'(dy_new[Y_W-1:1]));

    // one Bresenham step from the current cell
    assign dx_s   = $signed(ERR_W'(r_dx));
    assign dy_s   = $signed(ERR_W'(r_dy));
    assign step_x = r_err > -dx_s;
    assign step_y = r_err < dy_s;
    assign at_tgt = (r_x == r_tx) && (r_y == r_ty);

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_err = r_err;
        if (step_x) begin
            n_x = r_sx ? r_x + X_W'(1) : r_x - X_W'(1);
        end
        if (step_y) begin
            n_y = r_sy ? r_y + Y_W'(1) : r_y - Y_W'(1);
        end
        n_err = r_err - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
    end

    // RAM port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = f_addr(i_in_cell_x, i_in_cell_y);
        ram_wdata = i_in_blocked;
        ram_raddr = f_addr(r_vx, r_vy);
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 1'b0;
        end else if (in_acc && i_in_operation == OP_WRITE && tgt_in_map) begin
            ram_we = 1'b1;
        end
        if (r_state == S_WALK) begin
            ram_raddr = f_addr(n_x, n_y);
        end
    end

    blos_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control and result selection
    always_comb begin
        n_state   = r_state;
        fin       = 1'b0;
        fin_vis   = 1'b0;
        fin_query = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_operation == OP_QUERY && tgt_in_map && view_in_map) begin
                        n_state = S_WALK;
                    end else begin
                        fin       = 1'b1;
                        fin_query = (i_in_operation == OP_QUERY);
                    end
                end
            end
            S_WALK: begin
                if (ram_rdata || at_tgt) begin
                    fin       = 1'b1;
                    fin_vis   = !ram_rdata;
                    fin_query = 1'b1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = r_state;
        endcase
        if (fin) begin
            n_state = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VIEWER_X: r_vx <= i_cfg_data;
                    CFG_VIEWER_Y: r_vy <= i_cfg_data[Y_W-1:0];
                    default:      r_vx <= r_vx;
                endcase
            end
            if ((fin && out_free) || (r_state == S_HOLD && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= r_vx;
            r_y   <= r_vy;
            r_tx  <= i_in_cell_x;
            r_ty  <= i_in_cell_y;
            r_dx  <= dx_new;
            r_dy  <= dy_new;
            r_sx  <= (r_vx < i_in_cell_x);
            r_sy  <= (r_vy < i_in_cell_y);
            r_err <= err_new;
        end else if (r_state == S_WALK) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
        end
        if (fin) begin
            if (out_free) begin
                r_visible   <= fin_vis;
                r_was_query <= fin_query;
            end else begin
                r_pend_vis   <= fin_vis;
                r_pend_query <= fin_query;
            end
        end else if (r_state == S_HOLD && out_free) begin
            r_visible   <= r_pend_vis;
            r_was_query <= r_pend_query;
        end
    end

    // a finished item is held only while the output register is full
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("held result with empty output register");

    // the error term stays within the Bresenham bounds during a walk
    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_err <= dx_s) && (r_err >= -dy_s)))
        else $error("error term out of range");

    // a write transfer is acknowledged or held on the next cycle
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_operation == OP_WRITE) |=>
            ((r_state == S_HOLD) || (r_out_valid && !r_was_query && !r_visible)))
        else $error("write not acknowledged");

    // the walk never leaves the box spanned by viewer and target
    a_walk_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |->
            (((r_sx && r_x <= r_tx) || (!r_sx && r_x >= r_tx)) &&
             ((r_sy && r_y <= r_ty) || (!r_sy && r_y >= r_ty))))
        else $error("walk left the line box");

endmodule

`default_nettype wire

>>> sv/blos_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module blos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
